// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ----- hdl/slt_pkg.sv -----
package slt_pkg;

	// Sizing
	localparam int OFFSET_BITS     = 32;
	localparam int MAX_KEYWORD_LEN = 9;
	localparam int KW_IDX_W        = $clog2(MAX_KEYWORD_LEN);
	localparam int KW_LEN_W        = $clog2(MAX_KEYWORD_LEN + 1);

	// Token kinds
	localparam logic [4:0] KIND_EOF     = 5'd0;
	localparam logic [4:0] KIND_INT     = 5'd1;
	localparam logic [4:0] KIND_WORD    = 5'd2;
	localparam logic [4:0] KIND_STRING  = 5'd3;
	localparam logic [4:0] KIND_KW_BASE = 5'd4;

	// Keyword table; text is right-aligned, first character in the highest used byte
	localparam int KW_COUNT    = 21;
	localparam int KW_TEXT_LEN = 9;

	localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_COUNT] = '{
		"if", "if*", "else", "end", "while", "do", "include", "memory", "proc",
		"const", "offset", "reset", "assert", "in", "--", "inline", "here",
		"addr-of", "call-like", "let", "peek"
	};

	localparam int KW_LEN [KW_COUNT] = '{
		2, 3, 4, 3, 5, 2, 7, 6, 4, 5, 6, 5, 6, 2, 2, 6, 4, 7, 9, 3, 4
	};

	// Result FIFO sizing
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	typedef struct packed {
		logic [4:0]         kind;
		logic signed [63:0] value;
		logic [31:0]        start;
		logic [31:0]        length;
		logic               last;
	} res_t;

	// Results produced by one accepted item
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ----- hdl/slt_if.sv -----
interface slt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_source;

	modport source (output valid, output ch, output end_of_source, input ready);
	modport sink (input valid, input ch, input end_of_source, output ready);
endinterface

interface slt_out_if;
	logic               valid;
	logic               ready;
	logic [4:0]         token_kind;
	logic signed [63:0] int_value;
	logic [31:0]        start_offset;
	logic [31:0]        token_length;
	logic               last;

	modport source (output valid, output token_kind, output int_value,
		output start_offset, output token_length, output last, input ready);
	modport sink (input valid, input token_kind, input int_value,
		input start_offset, input token_length, input last, output ready);
endinterface

// ----- hdl/slt_kw_match.sv -----
module slt_kw_match (
	input  logic [7:0]                      kw_buf [slt_pkg::MAX_KEYWORD_LEN],
	input  logic [slt_pkg::OFFSET_BITS-1:0] len,
	input  logic                            too_long,
	output logic [4:0]                      kind
);

	logic [slt_pkg::KW_LEN_W-1:0] len_short;

	assign len_short = len[slt_pkg::KW_LEN_W-1:0];

	// Compare the buffered bytes against every keyword in parallel
	always_comb begin
		logic hit;
		int   idx;
		hit  = 1'b0;
		idx  = 0;
		kind = slt_pkg::KIND_WORD;
		if (!too_long &&
		    len <= slt_pkg::OFFSET_BITS'(slt_pkg::MAX_KEYWORD_LEN)) begin
			for (int i = slt_pkg::KW_COUNT - 1; i >= 0; i--) begin
				hit = (len_short == slt_pkg::KW_LEN_W'(slt_pkg::KW_LEN[i]));
				for (int j = 0; j < slt_pkg::KW_TEXT_LEN; j++) begin
					if (j < slt_pkg::KW_LEN[i]) begin
						idx = slt_pkg::KW_LEN[i] - 1 - j;
						if (kw_buf[j] != slt_pkg::KW_TEXT[i][8*idx +: 8])
							hit = 1'b0;
					end
				end
				// lowest index wins, so scan downward
				if (hit)
					kind = slt_pkg::KIND_KW_BASE + 5'(i);
			end
		end
	end

endmodule

// ----- hdl/slt_lexer.sv -----
module slt_lexer (
	input  logic           clk,
	input  logic           arst_n,
	slt_in_if.sink         src,
	input  logic           room,
	output slt_pkg::push_t push
);

	localparam int OB = slt_pkg::OFFSET_BITS;
	localparam int ML = slt_pkg::MAX_KEYWORD_LEN;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LF    = 8'h0A;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_SLASH   = 4'b0010,
		PH_COMMENT = 4'b0100,
		PH_TOKEN   = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		CL_INT   = 2'd0,
		CL_WORD  = 2'd1,
		CL_MINUS = 2'd2
	} class_t;

	phase_t        phase_q, phase_d;
	class_t        class_q, class_d;
	logic [63:0]   acc_q, acc_d;
	logic          neg_q, neg_d;
	logic [OB-1:0] pos_q, pos_d;
	logic [OB-1:0] start_q, start_d;
	logic          long_q, long_d;
	logic [7:0]    kw_buf_q [ML];

	logic                        buf_we;
	logic [slt_pkg::KW_IDX_W-1:0] buf_idx;

	logic          fire;
	logic [7:0]    b;
	logic          is_bnd, is_digit;
	logic [63:0]   digit;
	logic [OB-1:0] len;
	logic [4:0]    kw_kind;
	slt_pkg::res_t cur_res, eof_res, str_res;

	function automatic logic [31:0] off32(logic [OB-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

	assign fire      = src.valid && src.ready;
	assign src.ready = room;
	assign b         = src.ch;
	assign len       = pos_q - start_q;
	assign digit     = 64'(b - CH_ZERO);

	always_comb begin
		is_bnd   = b inside {8'h20, 8'h09, 8'h0B, 8'h0D, 8'h0A, 8'h00};
		is_digit = b inside {[CH_ZERO:CH_NINE]};
	end

	slt_kw_match u_kw_match (
		.kw_buf   (kw_buf_q),
		.len      (len),
		.too_long (long_q),
		.kind     (kw_kind)
	);

	// Build the candidate results from the current state
	always_comb begin
		cur_res.kind   = (class_q == CL_INT) ? slt_pkg::KIND_INT : kw_kind;
		cur_res.value  = (class_q != CL_INT) ? 64'sd0 :
		                 neg_q ? $signed(64'd0 - acc_q) : $signed(acc_q);
		cur_res.start  = off32(start_q);
		cur_res.length = off32(len);
		cur_res.last   = 1'b0;

		eof_res.kind   = slt_pkg::KIND_EOF;
		eof_res.value  = 64'sd0;
		eof_res.start  = off32(pos_q);
		eof_res.length = 32'd0;
		eof_res.last   = 1'b1;

		str_res.kind   = slt_pkg::KIND_STRING;
		str_res.value  = 64'sd0;
		str_res.start  = off32(pos_q);
		str_res.length = 32'd1;
		str_res.last   = 1'b1;
	end

	// Advance the scanner for one accepted item
	always_comb begin
		phase_d = phase_q;
		class_d = class_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		pos_d   = pos_q + OB'(1);
		start_d = start_q;
		long_d  = long_q;
		buf_we  = 1'b0;
		buf_idx = '0;
		push    = '0;

		if (src.end_of_source) begin
			// flush any open token, then report end and restart
			if (phase_q == PH_TOKEN || phase_q == PH_SLASH) begin
				push.n  = 2'd2;
				push.r0 = cur_res;
				push.r1 = eof_res;
			end else begin
				push.n  = 2'd1;
				push.r0 = eof_res;
			end
			phase_d = PH_IDLE;
			class_d = CL_INT;
			acc_d   = '0;
			neg_d   = 1'b0;
			pos_d   = '0;
			start_d = '0;
			long_d  = 1'b0;
		end else begin
			case (phase_q)
				PH_COMMENT: begin
					if (b == CH_LF)
						phase_d = PH_IDLE;
				end
				PH_IDLE: begin
					if (is_bnd) begin
						phase_d = PH_IDLE;
					end else if (b == CH_QUOTE) begin
						push.n  = 2'd1;
						push.r0 = str_res;
					end else begin
						// open a new token
						start_d = pos_q;
						long_d  = 1'b0;
						neg_d   = 1'b0;
						acc_d   = '0;
						buf_we  = 1'b1;
						if (b == CH_SLASH) begin
							class_d = CL_WORD;
							phase_d = PH_SLASH;
						end else if (is_digit) begin
							class_d = CL_INT;
							acc_d   = digit;
							phase_d = PH_TOKEN;
						end else if (b == CH_MINUS) begin
							class_d = CL_MINUS;
							neg_d   = 1'b1;
							phase_d = PH_TOKEN;
						end else begin
							class_d = CL_WORD;
							phase_d = PH_TOKEN;
						end
					end
				end
				PH_SLASH, PH_TOKEN: begin
					if (phase_q == PH_SLASH && b == CH_SLASH) begin
						phase_d = PH_COMMENT;
					end else if (is_bnd) begin
						push.n       = 2'd1;
						push.r0      = cur_res;
						push.r0.last = 1'b1;
						phase_d      = PH_IDLE;
					end else begin
						phase_d = PH_TOKEN;
						// append to the keyword buffer while it still fits
						if (!long_q && len < OB'(ML)) begin
							buf_we  = 1'b1;
							buf_idx = len[slt_pkg::KW_IDX_W-1:0];
						end else begin
							long_d = 1'b1;
						end
						case (class_q)
							CL_INT: begin
								if (is_digit)
									acc_d = (acc_q << 3) + (acc_q << 1) + digit;
								else
									class_d = CL_WORD;
							end
							CL_MINUS: begin
								if (is_digit) begin
									class_d = CL_INT;
									acc_d   = digit;
								end else begin
									class_d = CL_WORD;
								end
							end
							default: class_d = class_q;
						endcase
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end

		if (!fire)
			push.n = 2'd0;
	end

	// Hold scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			class_q <= CL_INT;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			pos_q   <= '0;
			start_q <= '0;
			long_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			class_q <= class_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			long_q  <= long_d;
		end
	end

	// Store token bytes for the keyword compare
	always_ff @(posedge clk) begin
		if (fire && buf_we)
			kw_buf_q[buf_idx] <= b;
	end

endmodule

// ----- hdl/slt_res_fifo.sv -----
module slt_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  slt_pkg::push_t push,
	output logic           room,
	slt_out_if.source      tok
);

	localparam int PW = slt_pkg::RES_PTR_W;
	localparam int CW = slt_pkg::RES_CNT_W;

	slt_pkg::res_t mem_q [slt_pkg::RES_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	slt_pkg::res_t head;

	// Leave space for the two results an end marker can produce
	assign room = cnt_q <= CW'(slt_pkg::RES_DEPTH - 2);
	assign pop  = tok.valid && tok.ready;
	assign head = mem_q[rd_q];

	assign tok.valid        = cnt_q != '0;
	assign tok.token_kind   = head.kind;
	assign tok.int_value    = head.value;
	assign tok.start_offset = head.start;
	assign tok.token_length = head.length;
	assign tok.last         = head.last;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push.n);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + CW'(push.n) - CW'(pop);
		end
	end

	// Write up to two results per cycle
	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wr_q + PW'(1)] <= push.r1;
	end

endmodule

// ----- hdl/stack_language_tokenizer.sv -----
// Channel  Dir  Payload                                                   Handshake
// src      in   ch[7:0], end_of_source                                    valid/ready
// tok      out  token_kind[4:0], int_value[63:0], start_offset[31:0],     valid/ready
//               token_length[31:0], last
//
// One source byte is taken per cycle while src.ready is high; its results enter a
// four-entry result FIFO the same cycle and can appear at tok on the next cycle.
// An end marker yields up to two results; src.ready drops while fewer than two FIFO
// entries are free, so a stalled tok side backs up into src after a few items.
// Reset clears the scanner and the FIFO; no clearing pass is needed.
`include "assert_macros.svh"

module stack_language_tokenizer (
	input  logic      clk,
	input  logic      arst_n,
	slt_in_if.sink    src,
	slt_out_if.source tok
);

	slt_pkg::push_t push;
	logic           room;

	slt_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.room   (room),
		.push   (push)
	);

	slt_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tok    (tok)
	);

	// An end marker always leaves an EOF waiting
	`ASSERT_NEXT(a_eof_follows_end, clk, arst_n, src.valid && src.ready && src.end_of_source, tok.valid)
	// EOF closes the results of its item and has no length
	`ASSERT_IMPLY(a_eof_last, clk, arst_n, tok.valid && tok.token_kind == slt_pkg::KIND_EOF, tok.last && tok.token_length == 32'd0)
	// Only int tokens carry a value
	`ASSERT_IMPLY(a_value_zero, clk, arst_n, tok.valid && tok.token_kind != slt_pkg::KIND_INT, tok.int_value == 64'sd0)
	// The FIFO never accepts an item without room for its results
	`ASSERT_IMPLY(a_push_room, clk, arst_n, push.n != 2'd0, room)

endmodule

// ----- tb/slt_token_check.sv -----
module slt_token_check (
	input  logic clk,
	input  logic arst_n,
	slt_in_if    src,
	slt_out_if   tok,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import slt_pkg::*;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_SLASH, SCAN_COMMENT, SCAN_TOKEN} scan_phase_t;
	typedef enum logic [1:0] {CLS_INT, CLS_WORD, CLS_MINUS} token_class_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Keywords in kind order, starting at KIND_KW_BASE
	string keywords [KW_COUNT] = '{
		"if", "if*", "else", "end", "while", "do", "include", "memory", "proc",
		"const", "offset", "reset", "assert", "in", "--", "inline", "here",
		"addr-of", "call-like", "let", "peek"
	};

	// Scanner state
	scan_phase_t  phase_q;
	token_class_t class_q;
	logic [63:0]  acc_q;
	logic         neg_q;
	logic [31:0]  pos_q;
	logic [31:0]  start_q;
	logic [7:0]   word_buf [MAX_KEYWORD_LEN];
	logic         overlong_q;

	// Tokens made by the current item, and tokens still due at tok
	res_t made [2];
	int   made_n;
	res_t tokens_due [$];

	int fail_count = 0;
	int due_count  = 0;

	assign mismatches  = fail_count;
	assign outstanding = due_count;

	function automatic bit is_boundary(logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_CR || b == CH_LF ||
			b == CH_NUL;
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic void clear_scan();
		phase_q    = SCAN_IDLE;
		class_q    = CLS_INT;
		acc_q      = '0;
		neg_q      = 1'b0;
		pos_q      = '0;
		start_q    = '0;
		overlong_q = 1'b0;
	endfunction

	function automatic void add_result(logic [4:0] kind, logic [63:0] value,
		logic [31:0] start, logic [31:0] length);
		made[made_n].kind   = kind;
		made[made_n].value  = value;
		made[made_n].start  = start;
		made[made_n].length = length;
		made[made_n].last   = 1'b0;
		made_n++;
	endfunction

	// Look the word up in the keyword list; long words never match
	function automatic logic [4:0] word_kind(int len);
		bit same;
		if (overlong_q || len > MAX_KEYWORD_LEN) begin
			return KIND_WORD;
		end
		for (int i = 0; i < KW_COUNT; i++) begin
			if (keywords[i].len() == len) begin
				same = 1'b1;
				for (int j = 0; j < len; j++) begin
					if (word_buf[j] != keywords[i][j]) begin
						same = 1'b0;
					end
				end
				if (same) begin
					return KIND_KW_BASE + 5'(i);
				end
			end
		end
		return KIND_WORD;
	endfunction

	function automatic void open_token(logic [7:0] b, token_class_t cls);
		start_q     = pos_q;
		overlong_q  = 1'b0;
		neg_q       = 1'b0;
		acc_q       = '0;
		word_buf[0] = b;
		class_q     = cls;
	endfunction

	function automatic void grow_token(logic [7:0] b);
		logic [31:0] len;
		len = pos_q - start_q;
		if (!overlong_q && len < MAX_KEYWORD_LEN) begin
			word_buf[len] = b;
		end else begin
			overlong_q = 1'b1;
		end
	endfunction

	function automatic void close_token();
		logic [31:0] len;
		len = pos_q - start_q;
		if (class_q == CLS_INT) begin
			add_result(KIND_INT, neg_q ? 64'd0 - acc_q : acc_q, start_q, len);
		end else begin
			add_result(word_kind(int'(len)), '0, start_q, len);
		end
		phase_q = SCAN_IDLE;
	endfunction

	// Advance the scanner by one item and queue the tokens it yields
	function automatic void predict_item(logic [7:0] b, logic eos);
		made_n = 0;
		if (eos) begin
			if (phase_q == SCAN_TOKEN || phase_q == SCAN_SLASH) begin
				close_token();
			end
			add_result(KIND_EOF, '0, pos_q, '0);
			clear_scan();
		end else begin
			case (phase_q)
				SCAN_COMMENT: begin
					if (b == CH_LF) begin
						phase_q = SCAN_IDLE;
					end
				end
				SCAN_IDLE: begin
					if (is_boundary(b)) begin
						// skip blanks between tokens
					end else if (b == CH_SLASH) begin
						open_token(b, CLS_WORD);
						phase_q = SCAN_SLASH;
					end else if (b == CH_QUOTE) begin
						add_result(KIND_STRING, '0, pos_q, 32'd1);
					end else if (is_digit(b)) begin
						open_token(b, CLS_INT);
						acc_q   = 64'(b - CH_ZERO);
						phase_q = SCAN_TOKEN;
					end else if (b == CH_MINUS) begin
						open_token(b, CLS_MINUS);
						neg_q   = 1'b1;
						phase_q = SCAN_TOKEN;
					end else begin
						open_token(b, CLS_WORD);
						phase_q = SCAN_TOKEN;
					end
				end
				default: begin
					if (phase_q == SCAN_SLASH && b == CH_SLASH) begin
						phase_q = SCAN_COMMENT;
					end else begin
						phase_q = SCAN_TOKEN;
						if (is_boundary(b)) begin
							close_token();
						end else begin
							grow_token(b);
							if (class_q == CLS_INT) begin
								if (is_digit(b)) begin
									acc_q = acc_q * 64'd10 + 64'(b - CH_ZERO);
								end else begin
									class_q = CLS_WORD;
								end
							end else if (class_q == CLS_MINUS) begin
								if (is_digit(b)) begin
									class_q = CLS_INT;
									acc_q   = 64'(b - CH_ZERO);
								end else begin
									class_q = CLS_WORD;
								end
							end
						end
					end
				end
			endcase
			pos_q = pos_q + 32'd1;
		end
		if (made_n > 0) begin
			made[made_n - 1].last = 1'b1;
		end
		for (int i = 0; i < made_n; i++) begin
			tokens_due.push_back(made[i]);
		end
	endfunction

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= 50) begin
			$display("%0t mismatch: %s", $realtime, what);
		end
	endtask

	// Compare one token at tok with the oldest one due
	task automatic check_token();
		res_t want;
		if (tokens_due.size() == 0) begin
			report_mismatch($sformatf("token kind %0d at %0d with none due",
				tok.token_kind, tok.start_offset));
			return;
		end
		want = tokens_due.pop_front();
		if (tok.token_kind !== want.kind) begin
			report_mismatch($sformatf("token_kind got %0d want %0d (start %0d)",
				tok.token_kind, want.kind, want.start));
		end
		if (tok.int_value !== want.value) begin
			report_mismatch($sformatf("int_value got %0d want %0d (start %0d)",
				tok.int_value, want.value, want.start));
		end
		if (tok.start_offset !== want.start) begin
			report_mismatch($sformatf("start_offset got %0d want %0d",
				tok.start_offset, want.start));
		end
		if (tok.token_length !== want.length) begin
			report_mismatch($sformatf("token_length got %0d want %0d (start %0d)",
				tok.token_length, want.length, want.start));
		end
		if (tok.last !== want.last) begin
			report_mismatch($sformatf("last got %0b want %0b (start %0d)",
				tok.last, want.last, want.start));
		end
	endtask

	// Watch both channels: predict on each accepted byte, check each accepted token
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			tokens_due.delete();
		end else begin
			if (src.valid === 1'b1 && src.ready === 1'b1) begin
				predict_item(src.ch, src.end_of_source);
			end
			if (tok.valid === 1'b1 && tok.ready === 1'b1) begin
				check_token();
			end
		end
		due_count = tokens_due.size();
	end

endmodule

// ----- tb/stack_language_tokenizer_tb.sv -----
module stack_language_tokenizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET  = 1650;
	localparam int CHOKE_CYCLES = 400;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	bit   choke_req;
	int   items_sent;
	int   mismatches;
	int   outstanding;

	logic [7:0] text_bytes [$];
	logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0B, 8'h0D, 8'h0A, 8'h00};
	string keyword_pool [21] = '{
		"if", "if*", "else", "end", "while", "do", "include", "memory", "proc",
		"const", "offset", "reset", "assert", "in", "--", "inline", "here",
		"addr-of", "call-like", "let", "peek"
	};

	slt_in_if  src_ch ();
	slt_out_if tok_ch ();

	stack_language_tokenizer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_ch),
		.tok    (tok_ch)
	);

	slt_token_check scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.src         (src_ch),
		.tok         (tok_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Mostly no gap, some short, a few long; none while steady
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void add_byte(logic [7:0] b);
		text_bytes.push_back(b);
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++) begin
			text_bytes.push_back(s[i]);
		end
	endfunction

	function automatic void add_printable(int n);
		for (int i = 0; i < n; i++) begin
			add_byte(8'($urandom_range(8'h21, 8'h7E)));
		end
	endfunction

	// Append one random token followed, usually, by blanks
	function automatic void add_token();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			if ($urandom_range(0, 2) == 0) begin
				add_byte(CH_MINUS);
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 9) == 0) begin
				add_printable(1);
			end
		end else if (pick < 45) begin
			add_str(keyword_pool[$urandom_range(0, 20)]);
			// near miss or overlong
			if ($urandom_range(0, 6) == 0) begin
				add_byte(8'h61 + 8'($urandom_range(0, 25)));
			end
		end else if (pick < 65) begin
			add_printable($urandom_range(1, 14));
		end else if (pick < 73) begin
			add_byte(CH_QUOTE);
		end else if (pick < 81) begin
			add_str("//");
			add_printable($urandom_range(0, 10));
			if ($urandom_range(0, 9) != 0) begin
				add_byte(CH_LF);
			end
		end else if (pick < 87) begin
			add_byte($urandom_range(0, 1) ? CH_SLASH : CH_MINUS);
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 6) != 0) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++) begin
				add_byte(blanks[$urandom_range(0, 5)]);
			end
		end
	endfunction

	// Offer one item and hold it until accepted
	task automatic push_item(logic [7:0] b, logic eos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			src_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_ch.valid         <= 1'b1;
		src_ch.ch            <= b;
		src_ch.end_of_source <= eos;
		@(posedge clk);
		while (src_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Send the buffered text, then the end marker with a random ignored byte
	task automatic play_text();
		foreach (text_bytes[i]) begin
			push_item(text_bytes[i], 1'b0);
		end
		push_item(8'($urandom_range(0, 255)), 1'b1);
		text_bytes.delete();
	endtask

	// Stimulus and verdict
	initial begin
		int texts;
		int n_tokens;
		int wait_cycles;
		arst_n               = 1'b0;
		src_ch.valid         = 1'b0;
		src_ch.ch            = 8'h00;
		src_ch.end_of_source = 1'b0;
		steady               = 1'b0;
		choke_req            = 1'b0;
		items_sent           = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// negative int, quote, lone slash, lone minus ended by NUL, top byte as word,
		// keyword, then end inside a comment
		add_str("-12\t");
		add_byte(CH_QUOTE);
		add_str("/ -");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_VT);
		add_str("if*\n//x");
		play_text();
		// lone minus and lone slash cut by the end marker, then an empty text
		add_str("-");
		play_text();
		add_str("/");
		play_text();
		play_text();

		// random texts of mostly well-formed tokens
		texts = 0;
		while (items_sent < ITEM_TARGET) begin
			steady = ($urandom_range(0, 3) == 0);
			if (texts == 8) begin
				choke_req = 1'b1;
			end
			if ($urandom_range(0, 3) == 0) begin
				add_byte(blanks[$urandom_range(0, 5)]);
			end
			n_tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			for (int i = 0; i < n_tokens; i++) begin
				add_token();
			end
			play_text();
			texts++;
		end
		src_ch.valid <= 1'b0;
		steady = 1'b0;
		// let the checker see the last accepted item
		@(posedge clk);

		// drain
		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Token sink: random stalls, and one long hold-off while bytes keep coming
	initial begin
		int gap;
		bit choke_done;
		tok_ch.ready = 1'b0;
		choke_done   = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (choke_req && !choke_done) begin
				choke_done = 1'b1;
				tok_ch.ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				tok_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tok_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Hard stop
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
